// File: hdl/rfpd_pkg.sv
package rfpd_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_V,
		ST_PREP,
		ST_DIV,
		ST_CLIP,
		ST_PULSE1,
		ST_PULSE2,
		ST_DONE
	} rfpd_state_t;

	// command modes
	localparam logic [1:0] MODE_ZERO  = 2'd0;
	localparam logic [1:0] MODE_ANGLE = 2'd1;
	localparam logic [1:0] MODE_PD    = 2'd2;

	// request kinds on tuser
	localparam logic ACT_CMD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_GAIN_P     = 3'd0;
	localparam logic [2:0] REG_GAIN_D     = 3'd1;
	localparam logic [2:0] REG_OFFSET_CH1 = 3'd2;
	localparam logic [2:0] REG_OFFSET_CH2 = 3'd3;
	localparam logic [2:0] REG_MIN_VEL    = 3'd4;
	localparam logic [2:0] REG_CLIP_LIMIT = 3'd5;
	localparam logic [2:0] REG_SETPOINT   = 3'd6;

	// reset values
	localparam logic [19:0] GAIN_P_RST     = 20'd30192;
	localparam logic [19:0] GAIN_D_RST     = 20'd6038;
	localparam logic [11:0] OFFSET_CH1_RST = 12'sd896;
	localparam logic [11:0] OFFSET_CH2_RST = -12'sd256;
	localparam logic [15:0] MIN_VEL_RST    = 16'd320;
	localparam logic [11:0] CLIP_LIMIT_RST = 12'd1280;
	localparam logic [11:0] PULSE_ONE_RST  = 12'd1558;
	localparam logic [11:0] PULSE_TWO_RST  = 12'd1483;

	// divider: quotient bits produced, last step index
	localparam int DIV_BITS = 15;
	localparam logic [3:0] DIV_LAST = 4'(DIV_BITS - 1);

endpackage

// File: hdl/roll_fin_pd_servo_controller_core.sv
// channel   dir  width  contents
// s_*       in   72+1   tdata: mode, angle, velocity, roll, roll_rate; tuser: action
// m_*       out  24     tdata: pulse_ch1, pulse_ch2
// cfg_*     in   3+20   register index and write data, written when cfg_wen is high
//
// a zero or angle command goes through the pulse steps for both channels to the result step,
// any other command or a tick outside pd mode goes straight to the result step; a pd tick
// first uses one shared 21x18 multiplier three times and a restoring divider that retires
// one quotient bit a cycle, then clips the quotient and goes through the pulse steps
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next request is taken while it waits
// arst_n clears configuration, mode, velocity and pulses to their reset values
module roll_fin_pd_servo_controller_core
	import rfpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // mode[1:0], angle[16:2], velocity[32:17], roll[48:33],
	                               // roll_rate[65:49], zero fill
	input  logic        s_tuser,   // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // pulse_ch1[11:0], pulse_ch2[23:12]
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_wdata
);

	// configuration registers
	logic        [19:0] gain_p_q;
	logic        [19:0] gain_d_q;
	logic signed [11:0] offset_ch1_q;
	logic signed [11:0] offset_ch2_q;
	logic        [15:0] min_velocity_q;
	logic        [11:0] clip_limit_q;
	logic signed [15:0] roll_setpoint_q;

	// held controller state
	logic [1:0]  mode_q;
	logic [15:0] velocity_q;
	logic [11:0] pulse_one_q;
	logic [11:0] pulse_two_q;

	// sequencer
	rfpd_state_t state_q, state_d;

	// latched measurements and working registers
	logic signed [15:0] roll_q;
	logic signed [16:0] rate_q;
	logic signed [38:0] prod_q;     // shared multiplier output
	logic signed [38:0] p_term_q;   // gain_p * error
	logic        [45:0] rem_q;      // divider partial remainder
	logic        [45:0] dsh_q;      // divisor aligned to current quotient bit
	logic [DIV_BITS-1:0] quo_q;
	logic [3:0]         div_cnt_q;
	logic               neg_q;
	logic               nz_q;
	logic signed [14:0] ang_q;      // fin angle feeding the pulse unit

	// output register
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	// unpacked request fields
	logic               in_action;
	logic [1:0]         in_mode;
	logic signed [14:0] in_angle;
	logic [15:0]        in_velocity;
	logic signed [15:0] in_roll;
	logic signed [16:0] in_rate;

	logic s_accept;
	logic out_load;

	// shared multiplier operands
	logic signed [20:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [38:0] mul_p;
	logic signed [16:0] err;
	logic        [15:0] v_eff;

	// numerator and divider
	logic signed [42:0] diff;
	logic        [42:0] diff_mag;
	logic               rem_ge;
	logic        [11:0] mag;

	// pulse unit
	logic signed [11:0] off_sel;
	logic        [11:0] pulse_new;

	// floor(1500 + (ang + off) * 25 / 384), saturated to 0..4095;
	// /384 is an arithmetic shift by 7 then a floor divide by 3 through a reciprocal
	function automatic logic [11:0] calc_pulse(input logic signed [14:0] ang,
	                                           input logic signed [11:0] off);
		logic signed [16:0] sum;
		logic signed [21:0] s25;
		logic signed [14:0] t;
		logic        [13:0] u;
		logic        [29:0] recip;
		logic        [12:0] q3;
		logic signed [14:0] pw;
		logic        [11:0] res;
		sum   = 17'(ang) + 17'(off);
		s25   = 22'(sum) * 22'sd25;
		t     = 15'(s25 >>> 7);
		// bias by 3*2048 so the divide sees a non-negative value
		u     = 14'(t + 15'sd6144);
		recip = 30'(u) * 30'd43691;
		q3    = 13'(recip >> 17);
		// remove the 2048 bias and add the 1500 center
		pw    = signed'({2'b00, q3}) - 15'sd548;
		if (pw < 0) begin
			res = 12'd0;
		end else if (pw > 15'sd4095) begin
			res = 12'd4095;
		end else begin
			res = pw[11:0];
		end
		return res;
	endfunction

	assign in_action   = s_tuser;
	assign in_mode     = s_tdata[1:0];
	assign in_angle    = s_tdata[16:2];
	assign in_velocity = s_tdata[32:17];
	assign in_roll     = s_tdata[48:33];
	assign in_rate     = s_tdata[65:49];

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// velocity floor for gain scheduling
	assign v_eff = (velocity_q < min_velocity_q) ? min_velocity_q : velocity_q;
	assign err   = 17'(roll_setpoint_q) - 17'(roll_q);

	// operand select for the one shared multiplier
	always_comb begin
		mul_a = signed'({1'b0, gain_p_q});
		mul_b = 18'(err);
		case (state_q)
			ST_MUL_D: begin
				mul_a = signed'({1'b0, gain_d_q});
				mul_b = 18'(rate_q);
			end
			ST_MUL_V: begin
				mul_a = signed'({5'b0, v_eff});
				mul_b = signed'({2'b0, v_eff});
			end
			default: begin
				mul_a = signed'({1'b0, gain_p_q});
				mul_b = 18'(err);
			end
		endcase
	end

	assign mul_p = 39'(mul_a * mul_b);

	// p - 8*d; the extra factor of 16 is applied as the remainder is loaded
	assign diff     = 43'(p_term_q) - 43'(prod_q <<< 3);
	assign diff_mag = diff[42] ? 43'(-diff) : 43'(diff);

	assign rem_ge = (rem_q >= dsh_q);

	// quotient above the clip limit saturates to it; a zero numerator gives zero whatever the divisor
	always_comb begin
		if (!nz_q) begin
			mag = 12'd0;
		end else if (quo_q > DIV_BITS'(clip_limit_q)) begin
			mag = clip_limit_q;
		end else begin
			mag = quo_q[11:0];
		end
	end

	assign off_sel   = (state_q == ST_PULSE2) ? offset_ch2_q : offset_ch1_q;
	assign pulse_new = calc_pulse(ang_q, off_sel);

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (in_action == ACT_CMD) begin
						if (in_mode == MODE_ZERO || in_mode == MODE_ANGLE) begin
							state_d = ST_PULSE1;
						end else begin
							state_d = ST_DONE;
						end
					end else if (mode_q == MODE_PD) begin
						state_d = ST_MUL_P;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL_P:  state_d = ST_MUL_D;
			ST_MUL_D:  state_d = ST_MUL_V;
			ST_MUL_V:  state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_CLIP;
				end
			end
			ST_CLIP:   state_d = ST_PULSE1;
			ST_PULSE1: state_d = ST_PULSE2;
			ST_PULSE2: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= GAIN_P_RST;
			gain_d_q        <= GAIN_D_RST;
			offset_ch1_q    <= OFFSET_CH1_RST;
			offset_ch2_q    <= OFFSET_CH2_RST;
			min_velocity_q  <= MIN_VEL_RST;
			clip_limit_q    <= CLIP_LIMIT_RST;
			roll_setpoint_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_GAIN_P:     gain_p_q        <= cfg_wdata;
				REG_GAIN_D:     gain_d_q        <= cfg_wdata;
				REG_OFFSET_CH1: offset_ch1_q    <= cfg_wdata[11:0];
				REG_OFFSET_CH2: offset_ch2_q    <= cfg_wdata[11:0];
				REG_MIN_VEL:    min_velocity_q  <= cfg_wdata[15:0];
				REG_CLIP_LIMIT: clip_limit_q    <= cfg_wdata[11:0];
				REG_SETPOINT:   roll_setpoint_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// mode, velocity, held pulses and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ZERO;
			velocity_q  <= '0;
			pulse_one_q <= PULSE_ONE_RST;
			pulse_two_q <= PULSE_TWO_RST;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (s_accept && in_action == ACT_CMD) begin
				mode_q     <= in_mode;
				velocity_q <= in_velocity;
			end
			if (state_q == ST_PULSE1) begin
				pulse_one_q <= pulse_new;
			end
			if (state_q == ST_PULSE2) begin
				pulse_two_q <= pulse_new;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {pulse_two_q, pulse_one_q};
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			roll_q <= in_roll;
			rate_q <= in_rate;
			// zero mode drives angle 0, angle mode the commanded angle
			ang_q  <= (in_mode == MODE_ANGLE) ? in_angle : '0;
		end
		prod_q <= mul_p;
		case (state_q)
			ST_MUL_D: begin
				p_term_q <= prod_q;
			end
			ST_MUL_V: begin
				rem_q <= {diff_mag[41:0], 4'b0000};
				neg_q <= diff[42];
				nz_q  <= (diff != '0);
			end
			ST_PREP: begin
				// prod_q now holds v^2; start at the top quotient bit
				dsh_q     <= {prod_q[31:0], 14'b0};
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q     <= {quo_q[DIV_BITS-2:0], rem_ge};
				dsh_q     <= dsh_q >> 1;
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			ST_CLIP: begin
				ang_q <= neg_q ? 15'(-signed'({3'b000, mag})) : signed'({3'b000, mag});
			end
			default: ;
		endcase
	end

	// held pulses only move in their own pulse step
	a_pulse_one_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_PULSE1 |=> $stable(pulse_one_q))
		else $error("pulse one changed outside its update step");

	a_pulse_two_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_PULSE2 |=> $stable(pulse_two_q))
		else $error("pulse two changed outside its update step");

	// a tick outside pd mode produces a result without any arithmetic
	a_tick_idle_mode: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && in_action == ACT_TICK && mode_q != MODE_PD |=> state_q == ST_DONE)
		else $error("tick outside pd mode did not go straight to result");

	// divider never runs past its last quotient bit
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_cnt_q <= DIV_LAST)
		else $error("divider step count out of range");

	// a new result appears only from the result step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the result step");

endmodule
